// ===== rtl/pli_pkg.sv =====
// Shared constants and field widths for the piecewise linear interpolator.
`timescale 1ns / 1ps

package pli_pkg;

   localparam int DEFAULT_MAX_POINTS = 64;

   // field widths
   localparam int CMD_W   = 1;
   localparam int IDX_W   = 6;
   localparam int VAL_W   = 32;
   localparam int PIU_W   = 7;
   localparam int REQ_W   = 104;   // 6 + 32 + 32 + 32 = 102, padded to whole bytes
   localparam int RSP_W   = 32;

   // fraction of the segment position, Q1.16
   localparam int FRAC_BITS = 16;
   localparam int STEP_W    = $clog2(FRAC_BITS);
   localparam int QUOT_W    = FRAC_BITS + 1;

   // request kinds
   localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

endpackage

// ===== rtl/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator: breakpoint tables, segment scan, divide and result stage.
`timescale 1ns / 1ps

// Holds up to MAX_POINTS breakpoints (signed Q16.16 x and y). A write request
// stores one point and returns nothing. A query request scans the segments
// from index 0 upward, one table read per cycle, and interpolates in the
// first segment whose ends hold the query x. A hit runs the 16-step
// restoring divider, then a multiply and an add, before the response; a
// zero-width segment skips them, and so does a scan over the n points in use
// that finds no segment holding x. With fewer than two points in use the
// query skips the scan too. The response side can hold off the result.
// The block takes no new request while a query is in progress.
// Tables are not cleared at reset: query only points that were written.
// Response tuser is the found flag; y_value is 0 when clear.
module piecewise_linear_interpolator
   import pli_pkg::*;
#(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic             clock,
   input  logic             reset,
   // register write: points_in_use
   input  logic             csr_wr_en,
   input  logic [PIU_W-1:0] csr_wr_data,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   // tdata: point_index[5:0], point_x[37:6], point_y[69:38], query_x[101:70], zeros
   input  logic [REQ_W-1:0] req_tdata,
   // tuser: command
   input  logic [CMD_W-1:0] req_tuser,
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // tdata: y_value[31:0]
   output logic [RSP_W-1:0] rsp_tdata,
   // tuser: found
   output logic             rsp_tuser
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int NW = ($clog2(MAX_POINTS + 1) > PIU_W) ? $clog2(MAX_POINTS + 1) : PIU_W;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FETCH = 8'b0000_0010,
      ST_PRIME = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_ADD   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   // request fields
   logic [IDX_W-1:0]        req_point_index;
   logic [VAL_W-1:0]        req_point_x;
   logic [VAL_W-1:0]        req_point_y;
   logic [VAL_W-1:0]        req_query_x;
   logic                    req_accept;

   assign req_point_index = req_tdata[5:0];
   assign req_point_x     = req_tdata[37:6];
   assign req_point_y     = req_tdata[69:38];
   assign req_query_x     = req_tdata[101:70];

   // tables
   logic [VAL_W-1:0]        x_mem [MAX_POINTS];
   logic [VAL_W-1:0]        y_mem [MAX_POINTS];
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;

   // control and datapath registers
   state_type               state_ff,     state_in;
   logic [PIU_W-1:0]        piu_ff,       piu_in;
   logic [IW-1:0]           addr_ff,      addr_in;
   logic [IW-1:0]           seg_ff,       seg_in;
   logic [NW-1:0]           last_seg_ff,  last_seg_in;
   logic [VAL_W-1:0]        x_rd_ff;
   logic [VAL_W-1:0]        y_rd_ff;
   logic signed [VAL_W-1:0] xq_ff,        xq_in;
   logic signed [VAL_W-1:0] x_prev_ff,    x_prev_in;
   logic signed [VAL_W-1:0] y_prev_ff,    y_prev_in;
   logic signed [VAL_W-1:0] y_hi_ff,      y_hi_in;
   logic [VAL_W-1:0]        w_ff,         w_in;
   logic [VAL_W-1:0]        rem_ff,       rem_in;
   logic [QUOT_W-1:0]       quot_ff,      quot_in;
   logic [STEP_W-1:0]       step_ff,      step_in;
   logic [VAL_W-1:0]        frac_prod_ff, frac_prod_in;
   logic [VAL_W-1:0]        y_res_ff,     y_res_in;
   logic                    found_res_ff, found_res_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]        rsp_tdata_ff,  rsp_tdata_in;
   logic                    rsp_found_ff,  rsp_found_in;

   // combinational helpers
   logic [NW-1:0]           n_pts;
   logic                    seg_hit;
   logic [VAL_W-1:0]        seg_width;
   logic [VAL_W-1:0]        seg_offset;
   logic [VAL_W:0]          rem_dbl;
   logic                    rem_ge;
   logic signed [VAL_W:0]   dy;
   logic signed [QUOT_W+VAL_W:0] prod_full;
   logic                    out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign wr_en   = req_accept && (req_tuser == CMD_WRITE)
                    && (32'(req_point_index) < 32'(MAX_POINTS));
   assign wr_addr = IW'(req_point_index);

   // point count clamped to the table depth
   assign n_pts = (32'(piu_ff) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(piu_ff);

   assign seg_hit    = (x_prev_ff <= xq_ff) && (xq_ff <= $signed(x_rd_ff));
   // both differences are non-negative on a hit, so the 32-bit wrap is exact
   assign seg_width  = x_rd_ff - x_prev_ff;
   assign seg_offset = xq_ff - x_prev_ff;

   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = (rem_dbl >= {1'b0, w_ff});

   assign dy        = {y_hi_ff[VAL_W-1], y_hi_ff} - {y_prev_ff[VAL_W-1], y_prev_ff};
   assign prod_full = $signed({1'b0, quot_ff}) * dy;

   always_comb begin
      state_in      = state_ff;
      piu_in        = piu_ff;
      addr_in       = addr_ff;
      seg_in        = seg_ff;
      last_seg_in   = last_seg_ff;
      xq_in         = xq_ff;
      x_prev_in     = x_prev_ff;
      y_prev_in     = y_prev_ff;
      y_hi_in       = y_hi_ff;
      w_in          = w_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      frac_prod_in  = frac_prod_ff;
      y_res_in      = y_res_ff;
      found_res_in  = found_res_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_found_in  = rsp_found_ff;

      if (csr_wr_en) begin
         piu_in = csr_wr_data;
      end

      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == CMD_QUERY)) begin
               xq_in        = req_query_x;
               addr_in      = '0;
               seg_in       = IW'(1);
               last_seg_in  = n_pts - NW'(1);
               y_res_in     = '0;
               found_res_in = 1'b0;
               if (n_pts < NW'(2)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            addr_in  = addr_ff + IW'(1);
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            x_prev_in = x_rd_ff;
            y_prev_in = y_rd_ff;
            addr_in   = addr_ff + IW'(1);
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (seg_hit) begin
               found_res_in = 1'b1;
               y_hi_in      = y_rd_ff;
               w_in         = seg_width;
               step_in      = '0;
               if (seg_width == '0) begin
                  y_res_in = y_prev_ff;
                  state_in = ST_EMIT;
               end else begin
                  // offset never exceeds width: integer bit of the fraction
                  if (seg_offset == seg_width) begin
                     quot_in = QUOT_W'(1);
                     rem_in  = '0;
                  end else begin
                     quot_in = '0;
                     rem_in  = seg_offset;
                  end
                  state_in = ST_DIV;
               end
            end else if (NW'(seg_ff) == last_seg_ff) begin
               state_in = ST_EMIT;
            end else begin
               x_prev_in = x_rd_ff;
               y_prev_in = y_rd_ff;
               seg_in    = seg_ff + IW'(1);
               addr_in   = addr_ff + IW'(1);
            end
         end
         ST_DIV: begin
            // one restoring step per cycle
            if (rem_ge) begin
               rem_in  = VAL_W'(rem_dbl - {1'b0, w_ff});
               quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_dbl[VAL_W-1:0];
               quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(FRAC_BITS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // arithmetic shift floors; only the low 32 bits of the sum matter
            frac_prod_in = prod_full[FRAC_BITS+VAL_W-1:FRAC_BITS];
            state_in     = ST_ADD;
         end
         ST_ADD: begin
            y_res_in = y_prev_ff + frac_prod_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = y_res_ff;
               rsp_found_in  = found_res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         piu_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         piu_ff        <= piu_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      seg_ff       <= seg_in;
      last_seg_ff  <= last_seg_in;
      xq_ff        <= xq_in;
      x_prev_ff    <= x_prev_in;
      y_prev_ff    <= y_prev_in;
      y_hi_ff      <= y_hi_in;
      w_ff         <= w_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      frac_prod_ff <= frac_prod_in;
      y_res_ff     <= y_res_in;
      found_res_ff <= found_res_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_found_ff <= rsp_found_in;
   end

   // breakpoint tables, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= req_point_x;
         y_mem[wr_addr] <= req_point_y;
      end
      x_rd_ff <= x_mem[addr_ff];
      y_rd_ff <= y_mem[addr_ff];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_found_ff;

   // a query keeps the request side closed on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == CMD_QUERY)) |=> !req_tready)
      else $error("query accepted but block ready next cycle");

   // not-found responses carry zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("response without found flag is not zero");

   // divider never runs on a zero-width segment
   a_div_width: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (w_ff != '0))
      else $error("divide by zero width");

   // restoring divider keeps its remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < w_ff))
      else $error("divider remainder out of range");

   // scan never passes the last point in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (NW'(seg_ff) <= last_seg_ff))
      else $error("segment scan past last point");

endmodule

// ===== tb/tb_piecewise_linear_interpolator.sv =====
// Self-checking testbench for the piecewise linear interpolator: table writes, lookups, checks.
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator;
   import pli_pkg::*;

   localparam int     CYCLE     = 12;
   localparam int     TABLE_SZ  = DEFAULT_MAX_POINTS;
   localparam int     SETTLE    = 2 * DEFAULT_MAX_POINTS + 40;
   localparam int     ITEM_GOAL = 1450;
   localparam int     PIU_MAX   = (1 << PIU_W) - 1;
   localparam longint VAL_MIN   = -64'sd2147483648;
   localparam longint VAL_MAX   = 64'sd2147483647;

   typedef enum int {
      SHAPE_RISING,
      SHAPE_STEPPED,
      SHAPE_NARROW,
      SHAPE_SCRAMBLED
   } table_shape_type;

   typedef struct {
      logic [VAL_W-1:0] y_value;
      logic             found;
   } lookup_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [PIU_W-1:0] csr_wr_data;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [CMD_W-1:0] req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   // shadow copy of the breakpoint tables and the live point count
   logic [VAL_W-1:0] x_tab [TABLE_SZ];
   logic [VAL_W-1:0] y_tab [TABLE_SZ];
   logic [PIU_W-1:0] live_points;

   lookup_type pending_lookups[$];

   int errors;
   int n_sent;
   int n_writes;
   int n_lookups;
   int n_hits;
   int n_flat;
   int n_phases;
   int rsp_hold;
   bit gapless_req;
   bit gapless_rsp;

   piecewise_linear_interpolator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CYCLE / 2) clock = ~clock;
   end

   initial begin
      #(CYCLE * 1200000);
      $display("piecewise_linear_interpolator test failed");
      $finish;
   end

   function automatic longint sx32(logic [VAL_W-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint unsigned rand64();
      return {$urandom(), $urandom()};
   endfunction

   // First segment holding qx wins; the fraction is truncated, the product shift floors.
   function automatic lookup_type interpolate(logic [VAL_W-1:0] qx, output bit flat);
      lookup_type r;
      int      n;
      longint  xq, x0, x1, y0, y1, w, t, yv;
      r.y_value = '0;
      r.found   = 1'b0;
      flat      = 1'b0;
      n  = (live_points > TABLE_SZ) ? TABLE_SZ : int'(live_points);
      xq = sx32(qx);
      for (int i = 0; i + 1 < n; i++) begin
         x0 = sx32(x_tab[i]);
         x1 = sx32(x_tab[i+1]);
         if (xq >= x0 && xq <= x1) begin
            y0 = sx32(y_tab[i]);
            y1 = sx32(y_tab[i+1]);
            w  = x1 - x0;
            r.found = 1'b1;
            if (w == 0) begin
               yv   = y0;
               flat = 1'b1;
            end else begin
               t  = ((xq - x0) <<< FRAC_BITS) / w;
               yv = y0 + ((t * (y1 - y0)) >>> FRAC_BITS);
            end
            r.y_value = yv[VAL_W-1:0];
            break;
         end
      end
      return r;
   endfunction

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                               logic [VAL_W-1:0] px, logic [VAL_W-1:0] py,
                               logic [VAL_W-1:0] qx);
      int         gap;
      bit         flat;
      lookup_type want;
      gap = gapless_req ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, qx, py, px, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
      if (cmd == CMD_WRITE) begin
         x_tab[idx] = px;
         y_tab[idx] = py;
         n_writes++;
      end else begin
         want = interpolate(qx, flat);
         pending_lookups.push_back(want);
         n_lookups++;
         n_hits += want.found;
         n_flat += flat;
      end
   endtask

   task automatic drain_lookups();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // register is only written with the block idle: drain, then let a write request settle
   task automatic set_points(int n);
      drain_lookups();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= PIU_W'(n);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      live_points = PIU_W'(n);
   endtask

   task automatic write_point(int idx, longint px, longint py);
      send_request(CMD_WRITE, IDX_W'(idx), px[VAL_W-1:0], py[VAL_W-1:0], $urandom());
   endtask

   task automatic lookup(longint qx);
      send_request(CMD_QUERY, IDX_W'($urandom_range(0, 63)), $urandom(), $urandom(),
                   qx[VAL_W-1:0]);
   endtask

   task automatic load_table(int count, table_shape_type shape);
      longint xv, step_max, step, yv;
      if (shape == SHAPE_NARROW) begin
         xv       = sx32($urandom()) >>> 8;
         step_max = $urandom_range(1, 64);
      end else begin
         xv       = VAL_MIN + longint'(rand64() % 64'h8000_0000);
         step_max = (count > 0) ? (VAL_MAX - xv) / count : 1;
      end
      for (int i = 0; i < count; i++) begin
         yv = ($urandom_range(0, 3) == 0) ? (sx32($urandom()) >>> 20) : sx32($urandom());
         if (shape == SHAPE_SCRAMBLED)
            xv = sx32($urandom());
         write_point(i, xv, yv);
         step = longint'(rand64() % longint'(step_max + 1));
         if (shape == SHAPE_STEPPED && $urandom_range(0, 2) == 0)
            step = 0;   // repeated x: zero-width segment
         else if (step == 0)
            step = 1;
         xv += step;
      end
   endtask

   function automatic longint pick_query(int n);
      int               i;
      longint           lo, hi;
      longint unsigned  span;
      if (n < 2 || $urandom_range(0, 9) == 0)
         return sx32($urandom());
      i  = $urandom_range(0, n - 2);
      lo = sx32(x_tab[i]);
      hi = sx32(x_tab[i+1]);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return lo - 1;
         3: return hi + 1;
         default: begin
            if (hi < lo)
               return lo;
            span = hi - lo;
            return lo + longint'(rand64() % (span + 1));
         end
      endcase
   endfunction

   always @(posedge clock) begin
      lookup_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            $error("response with no request waiting: y_value %h found %b",
                   rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_tdata !== want.y_value) begin
               $error("y_value mismatch: expected %h, actual %h", want.y_value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.found) begin
               $error("found mismatch: expected %b, actual %b", want.found, rsp_tuser);
               errors++;
            end
         end
         rsp_hold = gapless_rsp ? 0 : $urandom_range(0, 8);
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_empty_table();
      set_points(0);
      lookup(0);
      lookup(VAL_MIN);
   endtask

   task automatic test_single_point();
      write_point(0, VAL_MIN, VAL_MIN);
      write_point(1, VAL_MAX, VAL_MAX);
      set_points(1);
      lookup(0);
   endtask

   // widest possible segment and widest y swing
   task automatic test_full_span();
      set_points(2);
      lookup(VAL_MIN);
      lookup(VAL_MAX);
      lookup(0);
      lookup(-64'sd1);
      lookup(64'sh0001_0000);
   endtask

   task automatic test_falling_segment();
      write_point(63, -64'sd1, -64'sd1);
      write_point(0, -64'sd3, VAL_MAX);
      write_point(1, 64'sd4, VAL_MIN);
      lookup(0);
      lookup(64'sd1);
      lookup(-64'sd2);
      lookup(64'sd5);
   endtask

   task automatic test_zero_width();
      write_point(0, 64'sh0005_0000, 64'sh0000_1234);
      write_point(1, 64'sh0005_0000, -64'sh0007_0000);
      lookup(64'sh0005_0000);
      lookup(64'sh0005_0001);
      lookup(64'sh0004_ffff);
   endtask

   // every segment scanned, then the register above the table size
   task automatic test_full_table();
      load_table(TABLE_SZ, SHAPE_RISING);
      set_points(TABLE_SZ);
      lookup(sx32(x_tab[TABLE_SZ-1]));
      lookup(sx32(x_tab[TABLE_SZ-1]) + 1);
      lookup(sx32(x_tab[0]));
      set_points(PIU_MAX);
      lookup(sx32(x_tab[TABLE_SZ-1]));
      lookup(pick_query(TABLE_SZ));
   endtask

   task automatic test_random_mix();
      int              n, eff, ops;
      table_shape_type shape;
      while (n_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(0, 1);
            1:       n = TABLE_SZ;
            2:       n = $urandom_range(TABLE_SZ + 1, PIU_MAX);
            3:       n = $urandom_range(9, TABLE_SZ - 1);
            default: n = $urandom_range(2, 8);
         endcase
         eff   = (n > TABLE_SZ) ? TABLE_SZ : n;
         shape = table_shape_type'($urandom_range(0, 3));
         gapless_req = ($urandom_range(0, 3) == 0);
         gapless_rsp = ($urandom_range(0, 3) == 0);
         load_table(eff, shape);
         set_points(n);
         ops = $urandom_range(20, 50);
         repeat (ops) begin
            if ($urandom_range(0, 9) == 0)
               send_request(CMD_WRITE, IDX_W'($urandom_range(0, 63)), $urandom(),
                            $urandom(), $urandom());
            else
               lookup(pick_query(eff));
            if ($urandom_range(0, 39) == 0)
               drain_lookups();
         end
         n_phases++;
      end
   endtask

   initial begin
      errors      = 0;
      n_sent      = 0;
      n_writes    = 0;
      n_lookups   = 0;
      n_hits      = 0;
      n_flat      = 0;
      n_phases    = 0;
      rsp_hold    = 0;
      gapless_req = 1'b0;
      gapless_rsp = 1'b0;
      live_points = '0;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_WRITE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_single_point();
      test_full_span();
      test_falling_segment();
      test_zero_width();
      test_full_table();
      test_random_mix();

      drain_lookups();
      repeat (SETTLE) @(posedge clock);
      $display("Accepted %0d requests: %0d table writes, %0d lookups, %0d hits (%0d zero-width).",
               n_sent, n_writes, n_lookups, n_hits, n_flat);
      $display("Random part ran %0d table phases, point counts from 0 to %0d.",
               n_phases, PIU_MAX);
      if (errors == 0)
         $display("piecewise_linear_interpolator test passed");
      else
         $display("piecewise_linear_interpolator test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pli_pkg.sv
rtl/piecewise_linear_interpolator.sv
tb/tb_piecewise_linear_interpolator.sv
